// ===== sv/mfr_pkg.sv =====
`timescale 1ns / 1ps

package mfr_pkg;

	// Fixed field widths.
	localparam int CountW = 9;

	// Input opcodes.
	localparam logic [1:0] OP_CHAR    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// Receiver states, as reported in state_code.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RECV = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HEAD_BYTE   = 2'd0;
	localparam logic [1:0] CFG_TAIL_BYTE   = 2'd1;
	localparam logic [1:0] CFG_HEADER_LEN  = 2'd2;
	localparam logic [1:0] CFG_IDLE_RELOAD = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] HEAD_BYTE_RST   = 8'd104;
	localparam logic [7:0] TAIL_BYTE_RST   = 8'd22;
	localparam logic [4:0] HEADER_LEN_RST  = 5'd10;
	localparam logic [7:0] IDLE_RELOAD_RST = 8'd100;

	// Byte positions checked inside the header.
	localparam logic [CountW-1:0] SECOND_HEAD_POS = 9'd7;
	localparam logic [CountW-1:0] LENGTH_POS      = 9'd9;
	localparam logic [9:0]        TRAILER_LEN     = 10'd2;

	typedef struct packed {
		logic [7:0] head_byte;
		logic [7:0] tail_byte;
		logic [4:0] header_len;
		logic [7:0] idle_reload;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       ninth_bit;
	} in_item_t;

	typedef struct packed {
		logic              store_valid;
		logic [7:0]        store_index;
		logic [7:0]        store_data;
		logic              parity_error;
		logic              frame_aborted;
		logic              frame_done;
		logic              channel_reset;
		logic [1:0]        state_code;
		logic [CountW-1:0] frame_count;
	} result_t;

endpackage

// ===== sv/mfr_cfg.sv =====
`timescale 1ns / 1ps

module mfr_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output mfr_pkg::cfg_t cfg
);
	import mfr_pkg::*;

	cfg_t cfg_q;

	// Writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file with its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte   <= HEAD_BYTE_RST;
			cfg_q.tail_byte   <= TAIL_BYTE_RST;
			cfg_q.header_len  <= HEADER_LEN_RST;
			cfg_q.idle_reload <= IDLE_RELOAD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEAD_BYTE:   cfg_q.head_byte   <= cfg_data;
				CFG_TAIL_BYTE:   cfg_q.tail_byte   <= cfg_data;
				CFG_HEADER_LEN:  cfg_q.header_len  <= cfg_data[4:0];
				CFG_IDLE_RELOAD: cfg_q.idle_reload <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/mfr_core.sv =====
`timescale 1ns / 1ps

module mfr_core #(
	parameter int BUF_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mfr_pkg::cfg_t     cfg,
	input  logic              item_valid,
	input  mfr_pkg::in_item_t item,
	output mfr_pkg::result_t  res
);
	import mfr_pkg::*;

	localparam logic [CountW-1:0] BufLimit = CountW'(BUF_DEPTH);

	logic [1:0]        state_q, state_d, state_start;
	logic [CountW-1:0] count_q, count_d, count_inc;
	logic [7:0]        second_head_q, second_head_d;
	logic [7:0]        length_q, length_d;
	logic [7:0]        timer_q, timer_d, timer_dec;
	logic [9:0]        done_limit;
	logic              parity_ok;

	// Next state and the result of the item now in the input register.
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		second_head_d = second_head_q;
		length_d      = length_q;
		timer_d       = timer_q;
		res           = '0;
		parity_ok     = ((^item.data_byte) == item.ninth_bit);
		count_inc     = count_q + 1'b1;
		timer_dec     = timer_q - 1'b1;
		state_start   = state_q;
		done_limit    = '0;

		case (item.opcode)
			OP_CHAR: begin
				timer_d = cfg.idle_reload;
				if (!parity_ok) begin
					res.parity_error = 1'b1;
				end else begin
					if (state_q == ST_IDLE && item.data_byte == cfg.head_byte) begin
						state_start = ST_RECV;
					end
					state_d = state_start;
					if (state_start == ST_RECV && count_q < BufLimit) begin
						res.store_valid = 1'b1;
						res.store_index = count_q[7:0];
						res.store_data  = item.data_byte;
						if (count_q == SECOND_HEAD_POS) begin
							second_head_d = item.data_byte;
						end
						if (count_q == LENGTH_POS) begin
							length_d = item.data_byte;
						end
						count_d    = count_inc;
						done_limit = {2'b00, length_d} + {5'b00000, cfg.header_len}
							+ TRAILER_LEN;
						// Header checks start once the header is complete.
						if (count_inc > {4'b0000, cfg.header_len}) begin
							if (second_head_d != cfg.head_byte) begin
								state_d             = ST_IDLE;
								count_d             = '0;
								res.frame_aborted   = 1'b1;
							end else if ({1'b0, count_inc} >= done_limit
								&& item.data_byte == cfg.tail_byte) begin
								state_d        = ST_WAIT;
								res.frame_done = 1'b1;
							end
						end
					end
				end
			end
			OP_TICK: begin
				timer_d = timer_dec;
				if (timer_dec == 8'd0) begin
					state_d           = ST_IDLE;
					count_d           = '0;
					res.channel_reset = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (state_q == ST_WAIT) begin
					state_d = ST_IDLE;
					count_d = '0;
				end
			end
			default: ;
		endcase

		res.state_code  = state_d;
		res.frame_count = count_d;
	end

	// Receiver state, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			second_head_q <= '0;
			length_q      <= '0;
			timer_q       <= IDLE_RELOAD_RST;
		end else if (item_valid) begin
			state_q       <= state_d;
			count_q       <= count_d;
			second_head_q <= second_head_d;
			length_q      <= length_d;
			timer_q       <= timer_d;
		end
	end

	// A completed frame always leaves the receiver waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && res.frame_done) |=> (state_q == ST_WAIT))
		else $error("frame completion did not enter the wait state");

	// An abort returns to idle with an empty count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && res.frame_aborted) |=> (state_q == ST_IDLE && count_q == '0))
		else $error("abort left state or count behind");

	// A dropped character is never stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.parity_error |-> !res.store_valid)
		else $error("character with bad parity was stored");

	// A release in the wait state frees the receiver.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item.opcode == OP_RELEASE && state_q == ST_WAIT)
		|=> (state_q == ST_IDLE && count_q == '0))
		else $error("release did not return to idle");

	// The count never runs past the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= BufLimit)
		else $error("byte count beyond buffer depth");

endmodule

// ===== sv/meter_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

// Meter frame receiver: takes one item per clock (a 9-bit UART character, a
// timer tick or a frame release) and returns exactly one result item per input
// item, passing the input register and then the result register. The whole
// frame check is a single combinational step between those two registers, so
// the sustained rate is one item per cycle as long as the result side keeps
// taking items. The result tells where to write the received byte in an
// external frame buffer and flags parity drops, header aborts, frame completion
// and inactivity timeouts. The user must write configuration through the cfg port
// only while the block is idle, which it does not enforce. Writes are accepted every cycle.
module meter_frame_receiver_unit #(
	parameter int BUF_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // data_byte[7:0], ninth_bit[8], zero fill
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // store_valid[0], store_index[8:1],
	                                    // store_data[16:9], parity_error[17],
	                                    // frame_aborted[18], channel_reset[19],
	                                    // state_code[21:20], frame_count[30:22]
	output logic        m_axis_tlast    // frame_done
);
	import mfr_pkg::*;

	cfg_t     cfg;
	in_item_t in_s1;
	logic     in_valid_s1;
	result_t  res_comb;
	result_t  res_s2;
	logic     out_valid_s2;
	logic     advance;

	mfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The pipeline moves whenever the result register is free or being taken.
	assign advance       = !out_valid_s2 || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_s1.opcode    <= s_axis_tuser;
			in_s1.data_byte <= s_axis_tdata[7:0];
			in_s1.ninth_bit <= s_axis_tdata[8];
		end
	end

	mfr_core #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (in_valid_s1 && advance),
		.item       (in_s1),
		.res        (res_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	// Pack the result onto the output channel.
	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tlast  = res_s2.frame_done;
	assign m_axis_tdata  = {
		1'b0,
		res_s2.frame_count,
		res_s2.state_code,
		res_s2.channel_reset,
		res_s2.frame_aborted,
		res_s2.parity_error,
		res_s2.store_data,
		res_s2.store_index,
		res_s2.store_valid
	};

endmodule

// ===== sim/meter_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps

module meter_frame_receiver_unit_tb;
	import mfr_pkg::*;

	localparam int BufDepth   = 256;
	localparam int StallLimit = 2000;

	// Scoreboard: tracks the receiver state and holds the predicted result items.
	class frame_scoreboard;
		logic [7:0]        head_byte;
		logic [7:0]        tail_byte;
		logic [4:0]        header_len;
		logic [7:0]        idle_reload;
		logic [1:0]        rx_state;
		logic [CountW-1:0] held;
		logic [7:0]        second_head;
		logic [7:0]        length_field;
		logic [7:0]        idle_timer;
		int                depth;
		result_t           predicted_results[$];
		int items, results, mismatches;
		int frames, aborts, timeouts, parity_drops, full_drops;

		function new(int buf_depth);
			depth        = buf_depth;
			head_byte    = HEAD_BYTE_RST;
			tail_byte    = TAIL_BYTE_RST;
			header_len   = HEADER_LEN_RST;
			idle_reload  = IDLE_RELOAD_RST;
			rx_state     = ST_IDLE;
			held         = '0;
			second_head  = '0;
			length_field = '0;
			idle_timer   = IDLE_RELOAD_RST;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_HEAD_BYTE:   head_byte = val;
				CFG_TAIL_BYTE:   tail_byte = val;
				CFG_HEADER_LEN:  header_len = val[4:0];
				CFG_IDLE_RELOAD: idle_reload = val;
				default: ;
			endcase
		endfunction

		// Advance the receiver by one accepted item and queue the result it causes.
		function void predict_item(logic [1:0] op, logic [7:0] data, logic par);
			result_t r;
			r = '0;
			items++;
			case (op)
				OP_CHAR: begin
					idle_timer = idle_reload;
					if ((^data) != par) begin
						r.parity_error = 1'b1;
						parity_drops++;
					end else begin
						if (rx_state == ST_IDLE && data == head_byte)
							rx_state = ST_RECV;
						if (rx_state == ST_RECV && int'(held) >= depth)
							full_drops++;
						if (rx_state == ST_RECV && int'(held) < depth) begin
							r.store_valid = 1'b1;
							r.store_index = held[7:0];
							r.store_data  = data;
							if (held == SECOND_HEAD_POS)
								second_head = data;
							if (held == LENGTH_POS)
								length_field = data;
							held = held + 1'b1;
							if (held > {4'd0, header_len}) begin
								if (second_head != head_byte) begin
									rx_state = ST_IDLE;
									held = '0;
									r.frame_aborted = 1'b1;
									aborts++;
								end else if (int'(held) >= int'(length_field)
										+ int'(header_len) + int'(TRAILER_LEN)
										&& data == tail_byte) begin
									rx_state = ST_WAIT;
									r.frame_done = 1'b1;
									frames++;
								end
							end
						end
					end
				end
				OP_TICK: begin
					idle_timer = idle_timer - 1'b1;
					if (idle_timer == 8'd0) begin
						rx_state = ST_IDLE;
						held = '0;
						r.channel_reset = 1'b1;
						timeouts++;
					end
				end
				OP_RELEASE: begin
					if (rx_state == ST_WAIT) begin
						rx_state = ST_IDLE;
						held = '0;
					end
				end
				default: ;
			endcase
			r.state_code  = rx_state;
			r.frame_count = held;
			predicted_results.push_back(r);
		endfunction

		// Compare one result item with the oldest prediction, field by field.
		function void check_result(logic [31:0] tdata, logic tlast);
			result_t got;
			result_t want;
			got.store_valid   = tdata[0];
			got.store_index   = tdata[8:1];
			got.store_data    = tdata[16:9];
			got.parity_error  = tdata[17];
			got.frame_aborted = tdata[18];
			got.channel_reset = tdata[19];
			got.state_code    = tdata[21:20];
			got.frame_count   = tdata[30:22];
			got.frame_done    = tlast;
			results++;
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result item %0d arrived with none pending: tdata %h",
						results, tdata);
				return;
			end
			want = predicted_results.pop_front();
			if (got.store_valid !== want.store_valid || got.store_index !== want.store_index
					|| got.store_data !== want.store_data
					|| got.parity_error !== want.parity_error
					|| got.frame_aborted !== want.frame_aborted
					|| got.frame_done !== want.frame_done
					|| got.channel_reset !== want.channel_reset
					|| got.state_code !== want.state_code
					|| got.frame_count !== want.frame_count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"Result item %0d mismatch, wanted: st %0d idx %0d dat %h",
						" par %0d abt %0d done %0d rst %0d state %0d cnt %0d"},
						results, want.store_valid, want.store_index, want.store_data,
						want.parity_error, want.frame_aborted, want.frame_done,
						want.channel_reset, want.state_code, want.frame_count);
					$display({"  got:   st %0d idx %0d dat %h par %0d abt %0d done %0d",
						" rst %0d state %0d cnt %0d"},
						got.store_valid, got.store_index, got.store_data, got.parity_error,
						got.frame_aborted, got.frame_done, got.channel_reset,
						got.state_code, got.frame_count);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	bit              steady = 1'b0;
	int              stall_cycles = 0;
	frame_scoreboard sb = new(BufDepth);

	meter_frame_receiver_unit #(
		.BUF_DEPTH(BufDepth)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Result side: check each accepted item and stall at random.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
	end

	// Watchdog: end the run when no handshake completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("Watchdog: no handshake for %0d cycles.", StallLimit);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one input item, wait for it to be taken, then maybe leave a gap.
	task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic par);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, par, data};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.predict_item(op, data, par);
		if (!steady && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Hold the input side until every predicted result item has come back.
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		while (sb.predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg_port(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Drain the block, then rewrite all four registers.
	task automatic write_config(input logic [7:0] head, input logic [7:0] tail,
			input logic [4:0] hlen, input logic [7:0] reload);
		wait_results();
		write_reg_port(CFG_HEAD_BYTE, head);
		write_reg_port(CFG_TAIL_BYTE, tail);
		write_reg_port(CFG_HEADER_LEN, {3'd0, hlen});
		write_reg_port(CFG_IDLE_RELOAD, reload);
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	// Send one frame under the current settings; optionally break the second head
	// byte and sprinkle dropped characters and ticks between the bytes.
	task automatic send_frame(input int len, input bit bad_head, input bit noisy);
		int total;
		int idx;
		logic [7:0] b;
		total = len + int'(sb.header_len) + 2;
		for (idx = 0; idx < total; idx++) begin
			if (idx == 0 || idx == 7)
				b = sb.head_byte;
			else if (idx == 9)
				b = len[7:0];
			else if (idx == total - 1)
				b = sb.tail_byte;
			else
				b = 8'($urandom_range(0, 255));
			if (bad_head && idx == 7)
				b = sb.head_byte ^ 8'($urandom_range(1, 255));
			if (noisy && $urandom_range(0, 99) < 4)
				send_item(OP_CHAR, b, ~(^b));
			if (noisy && $urandom_range(0, 99) < 2)
				send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			send_item(OP_CHAR, b, ^b);
		end
	endtask

	// Random traffic: mostly frames, some broken frames, noise and tick bursts.
	task automatic run_phase(input int budget);
		int stop;
		int pick;
		int len;
		int n;
		stop = sb.items + budget;
		while (sb.items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				len = ($urandom_range(0, 99) < 6) ? $urandom_range(20, 60) : $urandom_range(0, 6);
				send_frame(len, 1'b0, 1'b1);
				if ($urandom_range(0, 99) < 85)
					send_item(OP_RELEASE, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				if ($urandom_range(0, 99) < 4)
					wait_results();
			end else if (pick < 72) begin
				send_frame($urandom_range(0, 6), 1'b1, 1'b1);
			end else if (pick < 88) begin
				send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				n = (sb.idle_reload <= 24) ? $urandom_range(1, int'(sb.idle_reload) + 1)
					: $urandom_range(1, 4);
				repeat (n)
					send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: parity drop, ignored idle byte, a minimal frame,
		// a character while waiting, and releases in and out of waiting.
		send_item(OP_CHAR, 8'hFF, 1'b1);
		send_item(OP_CHAR, 8'h00, 1'b0);
		send_frame(0, 1'b0, 1'b0);
		send_item(OP_CHAR, 8'hFF, 1'b0);
		send_item(OP_RELEASE, 8'hFF, 1'b1);
		send_item(OP_RELEASE, 8'h00, 1'b0);
		send_item(OP_TICK, 8'h00, 1'b0);

		// Shortest reload: the timer reloads only on a character, so these ticks count down the old timer.
		write_config(HEAD_BYTE_RST, TAIL_BYTE_RST, HEADER_LEN_RST, 8'd1);
		repeat (3)
			send_item(OP_TICK, 8'hFF, 1'b1);

		// Reset values again, with no idling on either side.
		write_config(HEAD_BYTE_RST, TAIL_BYTE_RST, HEADER_LEN_RST, IDLE_RELOAD_RST);
		steady = 1'b1;
		run_phase(75);
		wait_results();
		steady = 1'b0;

		write_config(8'h00, 8'hFF, 5'd16, 8'd255);
		run_phase(75);

		// Longest length field overflows the buffer; one tick clears the channel.
		write_config(8'hFF, 8'h00, 5'd10, 8'd1);
		send_frame(255, 1'b0, 1'b0);
		send_item(OP_TICK, 8'h5A, 1'b0);
		run_phase(75);

		repeat (3) begin
			write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				5'($urandom_range(10, 16)), 8'($urandom_range(2, 12)));
			run_phase(75);
		end

		write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 5'd13, 8'd200);
		run_phase(75);

		wait_results();
		repeat (8) @(posedge clk);

		$display("Ran %0d input items and %0d result items across nine register settings.",
			sb.items, sb.results);
		$display("Frames %0d, aborts %0d, timeouts %0d, parity drops %0d, full-buffer drops %0d.",
			sb.frames, sb.aborts, sb.timeouts, sb.parity_drops, sb.full_drops);
		if (sb.mismatches == 0 && sb.predicted_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("Mismatches %0d, results still pending %0d.", sb.mismatches,
				sb.predicted_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/mfr_pkg.sv
sv/mfr_cfg.sv
sv/mfr_core.sv
sv/meter_frame_receiver_unit.sv
sim/meter_frame_receiver_unit_tb.sv
